/* src/lsr_pkg.sv */
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants
// payload structs, register indexes, controller states and command bundles
// ----------------------------------------------------------------------------
package lsr_pkg;

	localparam int MAX_DOCS     = 64;
	localparam int MAX_FEATURES = 4;
	localparam int FIELD_COUNT  = 4;
	localparam int FEAT_LIMIT   = (MAX_FEATURES < FIELD_COUNT) ? MAX_FEATURES : FIELD_COUNT;
	localparam int ADDR_W       = $clog2(MAX_DOCS);
	localparam int COUNT_W      = $clog2(MAX_DOCS + 1);
	localparam int SCORE_W      = 36;
	localparam int ID_W         = 32;
	localparam int ENTRY_W      = SCORE_W + ID_W;

	localparam logic [2:0] REG_WEIGHT_ZERO  = 3'd0;
	localparam logic [2:0] REG_WEIGHT_ONE   = 3'd1;
	localparam logic [2:0] REG_WEIGHT_TWO   = 3'd2;
	localparam logic [2:0] REG_WEIGHT_THREE = 3'd3;
	localparam logic [2:0] REG_SCORE_BIAS   = 3'd4;
	localparam logic [2:0] REG_FEATURES     = 3'd5;

	typedef struct packed {
		logic signed [31:0] document_id;
		logic signed [15:0] feature_zero;
		logic signed [15:0] feature_one;
		logic signed [15:0] feature_two;
		logic signed [15:0] feature_three;
		logic               last_document;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] ranked_id;
		logic               ranked_last;
		logic               dropped_some;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCORE,
		ST_SEARCH,
		ST_SHIFT,
		ST_WRITE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic               load;      // capture item, start score
		logic               mac;       // one multiply-accumulate step
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic               wr_new;    // write new entry instead of shifted one
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mac_done;
		logic rd_less;   // entry just read scores below the new one
		logic last;
	} dp_sts_t;

endpackage

/* src/linear_score_rerank_core.sv */
// ----------------------------------------------------------------------------
// linear_score_rerank_core: linear scorer with stable descending ranking
// busy per document: scoring over the features in use, the walk from the tail
// that shifts lower scoring entries one place down, and the write of the new
// entry; a document that finds the store full is scored and not stored. one
// document at a time, set by the serial multiplier and the single write port of
// the store. on a last document the ranking follows with one result per cycle.
// the receiver cannot stall. asynchronous reset empties the store and loads
// register reset values.
// ----------------------------------------------------------------------------
module linear_score_rerank_core (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  start,
	output logic                  busy,
	input  lsr_pkg::in_item_t     item,
	// result channel, one transfer per strobe
	output logic                  result_valid,
	output lsr_pkg::out_item_t    result,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	logic signed [15:0] weight_q [lsr_pkg::FIELD_COUNT];
	logic signed [31:0] bias_q;
	logic [2:0]         fiu_q;
	lsr_pkg::dp_cmd_t   cmd;
	lsr_pkg::dp_sts_t   sts;
	logic signed [31:0] rd_id;
	logic               emit_valid, emit_last, emit_drop;

	// configuration is always taken; writes land only while idle by contract
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lsr_pkg::FIELD_COUNT; i++) begin
				weight_q[i] <= '0;
			end
			bias_q <= '0;
			fiu_q  <= 3'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				lsr_pkg::REG_WEIGHT_ZERO:  weight_q[0] <= cfg_data[15:0];
				lsr_pkg::REG_WEIGHT_ONE:   weight_q[1] <= cfg_data[15:0];
				lsr_pkg::REG_WEIGHT_TWO:   weight_q[2] <= cfg_data[15:0];
				lsr_pkg::REG_WEIGHT_THREE: weight_q[3] <= cfg_data[15:0];
				lsr_pkg::REG_SCORE_BIAS:   bias_q      <= cfg_data;
				lsr_pkg::REG_FEATURES:     fiu_q       <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	lsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sts       (sts),
		.cmd       (cmd),
		.emit_valid(emit_valid),
		.emit_last (emit_last),
		.emit_drop (emit_drop)
	);

	lsr_datapath u_dp (
		.clk            (clk),
		.item           (item),
		.weight         (weight_q),
		.score_bias     (bias_q),
		.features_in_use(fiu_q),
		.cmd            (cmd),
		.sts            (sts),
		.rd_id          (rd_id)
	);

	// id comes straight off the registered ram read
	assign result_valid        = emit_valid;
	assign result.ranked_id    = rd_id;
	assign result.ranked_last  = emit_last;
	assign result.dropped_some = emit_drop;
endmodule

/* src/lsr_ram.sv */
// ----------------------------------------------------------------------------
// lsr_ram: generic single-port-write ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

/* src/lsr_datapath.sv */
// ----------------------------------------------------------------------------
// lsr_datapath: scoring and store datapath
// serial multiply-accumulate, sorted store ram and compare
// ----------------------------------------------------------------------------
module lsr_datapath (
	input  logic                       clk,
	input  lsr_pkg::in_item_t          item,
	input  logic signed [15:0]         weight [lsr_pkg::FIELD_COUNT],
	input  logic signed [31:0]         score_bias,
	input  logic [2:0]                 features_in_use,
	input  lsr_pkg::dp_cmd_t           cmd,
	output lsr_pkg::dp_sts_t           sts,
	output logic signed [31:0]         rd_id
);
	localparam int FI_W = $clog2(lsr_pkg::FIELD_COUNT + 1);

	logic signed [15:0]                 feat_q [lsr_pkg::FIELD_COUNT];
	logic signed [31:0]                 id_q;
	logic                               last_q;
	logic [FI_W-1:0]                    fidx_q;
	logic [FI_W-1:0]                    limit_q;
	logic signed [lsr_pkg::SCORE_W-1:0] acc_q;
	logic signed [31:0]                 prod;
	logic [lsr_pkg::ENTRY_W-1:0]        rd_data;
	logic [lsr_pkg::ENTRY_W-1:0]        wr_data;
	logic [2:0]                         lim;

	always_comb begin
		lim = features_in_use;
		if (lim > 3'(lsr_pkg::FEAT_LIMIT)) begin
			lim = 3'(lsr_pkg::FEAT_LIMIT);
		end
	end

	assign prod = feat_q[fidx_q[FI_W-2:0]] * weight[fidx_q[FI_W-2:0]];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			feat_q[0] <= item.feature_zero;
			feat_q[1] <= item.feature_one;
			feat_q[2] <= item.feature_two;
			feat_q[3] <= item.feature_three;
			id_q      <= item.document_id;
			last_q    <= item.last_document;
			fidx_q    <= '0;
			limit_q   <= FI_W'(lim);
			acc_q     <= lsr_pkg::SCORE_W'(score_bias);
		end else if (cmd.mac && (fidx_q < limit_q)) begin
			acc_q  <= acc_q + lsr_pkg::SCORE_W'(prod);
			fidx_q <= fidx_q + 1'b1;
		end
	end

	// new entry or the one just read, moved one place down
	assign wr_data = cmd.wr_new ? {acc_q, id_q} : rd_data;

	lsr_ram #(.WIDTH(lsr_pkg::ENTRY_W), .DEPTH(lsr_pkg::MAX_DOCS)) u_store (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(cmd.wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_data)
	);

	assign sts.mac_done = (fidx_q >= limit_q);
	assign sts.rd_less  = $signed(rd_data[lsr_pkg::ENTRY_W-1:lsr_pkg::ID_W]) < acc_q;
	assign sts.last     = last_q;
	assign rd_id        = rd_data[lsr_pkg::ID_W-1:0];
endmodule

/* src/lsr_ctrl.sv */
// ----------------------------------------------------------------------------
// lsr_ctrl: sequencer for scoring, sorted insert and emission
// walks the store from the tail while shifting, then reads it out in order
// ----------------------------------------------------------------------------
module lsr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lsr_pkg::dp_sts_t             sts,
	output lsr_pkg::dp_cmd_t             cmd,
	output logic                         emit_valid,
	output logic                         emit_last,
	output logic                         emit_drop
);
	lsr_pkg::state_t state_q, state_d;
	logic [lsr_pkg::COUNT_W-1:0] count_q, count_d;
	logic [lsr_pkg::COUNT_W-1:0] pos_q, pos_d;   // free slot while shifting
	logic                        ovf_q, ovf_d;
	logic                        pend_q, pend_d; // a read is in flight in emit

	function automatic logic [lsr_pkg::ADDR_W-1:0] lsr_lsb(
		input logic [lsr_pkg::COUNT_W-1:0] v);
		lsr_lsb = v[lsr_pkg::ADDR_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsr_pkg::ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			ovf_q   <= ovf_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		ovf_d      = ovf_q;
		pend_d     = 1'b0;
		cmd        = '0;
		emit_valid = 1'b0;
		emit_last  = 1'b0;
		emit_drop  = ovf_q;
		busy       = (state_q != lsr_pkg::ST_IDLE);
		unique case (state_q)
			lsr_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = lsr_pkg::ST_SCORE;
				end
			end
			lsr_pkg::ST_SCORE: begin
				cmd.mac = 1'b1;
				if (sts.mac_done) begin
					pos_d = count_q;
					if (count_q == lsr_pkg::COUNT_W'(lsr_pkg::MAX_DOCS)) begin
						ovf_d = 1'b1;
						if (sts.last) begin
							state_d = lsr_pkg::ST_EMIT;
							pos_d   = '0;
						end else begin
							state_d = lsr_pkg::ST_IDLE;
						end
					end else if (count_q == '0) begin
						state_d = lsr_pkg::ST_WRITE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = lsr_lsb(count_q - 1'b1);
						state_d     = lsr_pkg::ST_SEARCH;
					end
				end
			end
			lsr_pkg::ST_SEARCH: begin
				// entry pos-1 is on the read port
				if (sts.rd_less) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = lsr_lsb(pos_q);
					pos_d       = pos_q - 1'b1;
					if (pos_q == lsr_pkg::COUNT_W'(1)) begin
						state_d = lsr_pkg::ST_WRITE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = lsr_lsb(pos_q - 2'd2);
					end
				end else begin
					state_d = lsr_pkg::ST_WRITE;
				end
			end
			lsr_pkg::ST_WRITE: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_new  = 1'b1;
				cmd.wr_addr = lsr_lsb(pos_q);
				count_d     = count_q + 1'b1;
				pos_d       = '0;
				state_d     = sts.last ? lsr_pkg::ST_EMIT : lsr_pkg::ST_IDLE;
			end
			lsr_pkg::ST_EMIT: begin
				// pos counts reads issued; each result shows in the cycle after its read
				emit_valid = pend_q;
				emit_last  = pend_q && (pos_q == count_q);
				if (pos_q < count_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = lsr_lsb(pos_q);
					pos_d       = pos_q + 1'b1;
					pend_d      = 1'b1;
				end else begin
					state_d = lsr_pkg::ST_IDLE;
					count_d = '0;
					ovf_d   = 1'b0;
				end
			end
			default: state_d = lsr_pkg::ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lsr_pkg::COUNT_W'(lsr_pkg::MAX_DOCS))
		else $error("stored count above capacity");
	a_emit_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid |-> (state_q == lsr_pkg::ST_EMIT))
		else $error("result outside emission");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_valid && emit_last) |=> (count_q == '0) && !ovf_q)
		else $error("store not emptied after ranking");
`endif
endmodule

/* tb/lsr_checker.sv */
// ----------------------------------------------------------------------------
// lsr_checker: ranking predictor and result comparison
// watches accepted documents, configuration writes and result strobes; keeps
// its own sorted store and compares every ranked id with the oldest expected
// ----------------------------------------------------------------------------
module lsr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  lsr_pkg::in_item_t  item,
	input  logic               result_valid,
	input  lsr_pkg::out_item_t result,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);
	logic signed [15:0] weight_q [lsr_pkg::FIELD_COUNT];
	logic signed [31:0] bias_q;
	logic [2:0]         feat_q;

	logic signed [lsr_pkg::SCORE_W-1:0] rank_score [$];
	logic signed [lsr_pkg::ID_W-1:0]    rank_id [$];
	logic                               dropped_q;
	lsr_pkg::out_item_t                 ranking_q [$];

	function automatic logic signed [lsr_pkg::SCORE_W-1:0] doc_score(lsr_pkg::in_item_t d);
		logic signed [lsr_pkg::SCORE_W-1:0] acc;
		logic signed [15:0]                 feat [lsr_pkg::FIELD_COUNT];
		int                                 lim;
		feat[0] = d.feature_zero;
		feat[1] = d.feature_one;
		feat[2] = d.feature_two;
		feat[3] = d.feature_three;
		lim = (feat_q > lsr_pkg::FEAT_LIMIT) ? lsr_pkg::FEAT_LIMIT : feat_q;
		acc = bias_q;
		for (int f = 0; f < lim; f++)
			acc += lsr_pkg::SCORE_W'(feat[f] * weight_q[f]);
		return acc;
	endfunction

	task automatic take_document(lsr_pkg::in_item_t d);
		logic signed [lsr_pkg::SCORE_W-1:0] s;
		int                                 pos;
		lsr_pkg::out_item_t                 r;
		s = doc_score(d);
		if (rank_score.size() < lsr_pkg::MAX_DOCS) begin
			// stable: goes behind every entry scoring greater or equal
			pos = rank_score.size();
			while (pos > 0 && rank_score[pos-1] < s)
				pos--;
			rank_score.insert(pos, s);
			rank_id.insert(pos, d.document_id);
		end else
			dropped_q = 1'b1;
		if (d.last_document) begin
			foreach (rank_id[k]) begin
				r.ranked_id    = rank_id[k];
				r.ranked_last  = (k == rank_id.size() - 1);
				r.dropped_some = dropped_q;
				ranking_q.push_back(r);
			end
			rank_score.delete();
			rank_id.delete();
			dropped_q = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lsr_pkg::out_item_t e;
		if (!arst_n) begin
			for (int f = 0; f < lsr_pkg::FIELD_COUNT; f++)
				weight_q[f] = '0;
			bias_q = '0;
			feat_q = 3'd4;
			rank_score.delete();
			rank_id.delete();
			ranking_q.delete();
			dropped_q = 1'b0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid) begin
				if (ranking_q.size() == 0) begin
					$error("unexpected result id %0d", result.ranked_id);
					fail_count++;
				end else begin
					e = ranking_q.pop_front();
					if (result.ranked_id !== e.ranked_id) begin
						$error("ranked_id expected %0d actual %0d", e.ranked_id,
							result.ranked_id);
						fail_count++;
					end
					if (result.ranked_last !== e.ranked_last) begin
						$error("ranked_last expected %0b actual %0b", e.ranked_last,
							result.ranked_last);
						fail_count++;
					end
					if (result.dropped_some !== e.dropped_some) begin
						$error("dropped_some expected %0b actual %0b", e.dropped_some,
							result.dropped_some);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index) inside
					lsr_pkg::REG_WEIGHT_ZERO, lsr_pkg::REG_WEIGHT_ONE,
					lsr_pkg::REG_WEIGHT_TWO, lsr_pkg::REG_WEIGHT_THREE:
						weight_q[cfg_index[1:0]] = cfg_data[15:0];
					lsr_pkg::REG_SCORE_BIAS: bias_q = cfg_data;
					lsr_pkg::REG_FEATURES:   feat_q = cfg_data[2:0];
					default: ;
				endcase
			end
			if (start && !busy)
				take_document(item);
			pending = ranking_q.size();
		end
	end
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: linear score rerank testbench
// drives document sets and register settings into the core; the checker
// predicts each ranking and counts mismatches, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	lsr_pkg::in_item_t  item;
	logic               result_valid;
	lsr_pkg::out_item_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 fail_count;
	int                 pending;

	// burst / gap pacing of the document sender
	int burst_left;
	int gap_left;
	int sent;

	linear_score_rerank_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lsr_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one register write, waits for its transfer, then drops cfg_valid before returning
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every ranking is out and the core is idle
	task automatic drain;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// random value with a bias towards the field extremes
	function automatic logic [15:0] pick16;
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// one document, paced by the burst pattern; start held until the transfer
	task automatic send_doc(logic signed [31:0] id, logic [15:0] f0, logic [15:0] f1,
		logic [15:0] f2, logic [15:0] f3, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap_left > 0) begin
				start <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item  <= '{document_id: id, feature_zero: f0, feature_one: f1,
			feature_two: f2, feature_three: f3, last_document: last};
		do @(posedge clk); while (busy);
		sent++;
		if (last) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic random_set(int n, bit ties);
		logic [15:0] f;
		for (int k = 0; k < n; k++) begin
			f = ties ? 16'($urandom_range(0, 3)) : pick16();
			send_doc($urandom, f, ties ? f : pick16(), pick16(), pick16(), k == n - 1);
		end
	endtask

	task automatic random_cfg;
		logic [31:0] b;
		for (int r = 0; r < 4; r++)
			write_reg(3'(r), {16'($urandom), pick16()});
		case ($urandom_range(0, 2))
			0: b = 32'h8000_0000;
			1: b = 32'h7fff_ffff;
			default: b = $urandom;
		endcase
		write_reg(lsr_pkg::REG_SCORE_BIAS, b);
		write_reg(lsr_pkg::REG_FEATURES, 32'($urandom_range(0, 7)));
		// out of range index, ignored
		if ($urandom_range(0, 3) == 0)
			write_reg(3'($urandom_range(6, 7)), $urandom);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		burst_left = 0;
		sent       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weights: every score equals the bias, arrival order kept
		send_doc(32'sh8000_0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
		send_doc(32'sh7fff_ffff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
		send_doc(32'sd0, 16'h0000, 16'hffff, 16'h0001, 16'h0000, 1'b1);
		// set of one document
		send_doc(32'sd7, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		drain();

		// extreme weights, all features in use
		write_reg(lsr_pkg::REG_WEIGHT_ZERO, 32'h0000_7fff);
		write_reg(lsr_pkg::REG_WEIGHT_ONE, 32'hffff_8000);
		write_reg(lsr_pkg::REG_WEIGHT_TWO, 32'h0000_8000);
		write_reg(lsr_pkg::REG_WEIGHT_THREE, 32'h0000_7fff);
		write_reg(lsr_pkg::REG_SCORE_BIAS, 32'h8000_0000);
		write_reg(lsr_pkg::REG_FEATURES, 32'd4);
		send_doc(32'sd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_doc(32'sd2, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
		send_doc(32'sd3, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
		send_doc(32'sd4, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		drain();

		// no features in use: bias alone
		write_reg(lsr_pkg::REG_FEATURES, 32'd0);
		write_reg(lsr_pkg::REG_SCORE_BIAS, 32'h7fff_ffff);
		send_doc(32'sd10, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_doc(32'sd11, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		drain();
		// count above the limit saturates
		write_reg(lsr_pkg::REG_FEATURES, 32'd7);
		send_doc(32'sd20, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 1'b0);
		send_doc(32'sd21, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1);
		drain();
		// one feature only
		write_reg(lsr_pkg::REG_FEATURES, 32'd1);
		send_doc(32'sd30, 16'h0001, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
		send_doc(32'sd31, 16'h0002, 16'h8000, 16'h8000, 16'h8000, 1'b1);
		drain();

		// store full: overflow on the last document too
		random_set(lsr_pkg::MAX_DOCS + 2, 1'b1);
		drain();

		// random phases, mostly small sets
		while (sent < 120) begin
			random_cfg();
			for (int s = 0; s < 3; s++)
				random_set(($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8), $urandom_range(0, 2) == 0);
			drain();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

/* linear_score_rerank_core.f */
src/lsr_pkg.sv
src/lsr_ram.sv
src/lsr_datapath.sv
src/lsr_ctrl.sv
src/linear_score_rerank_core.sv
tb/lsr_checker.sv
tb/tb_top.sv
